>>> src/physical_page_free_stack_macros.svh
// Assertion macros for the page allocator; only the execution module uses them.
`ifndef PHYSICAL_PAGE_FREE_STACK_MACROS_SVH
`define PHYSICAL_PAGE_FREE_STACK_MACROS_SVH
`ifndef SYNTHESIS
`define PPFS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PPFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPFS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define PPFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> src/ppfs_pkg.sv
// Types and constants of the physical page allocator.
`timescale 1ns / 1ps
package ppfs_pkg;
    localparam int unsigned NUM_PAGES_DEF = 1024;
    localparam int unsigned PAGE_SHIFT    = 12;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned PADDR_W       = 3;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0040_0000;
    localparam logic [PADDR_W-3:0] REG_BASE_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        KIND_ALLOC,
        KIND_FREE,
        KIND_BAD
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED     = 3'd0,
        ST_NONE_FREE     = 3'd1,
        ST_FREED         = 3'd2,
        ST_BAD_ADDRESS   = 3'd3,
        ST_NOT_ALLOCATED = 3'd4
    } status_t;

    typedef enum logic {
        B_IDLE,
        B_EXEC
    } back_state_t;
endpackage

>>> src/ppfs_front.sv
// Request intake: handshake and address classification.
`timescale 1ns / 1ps
module ppfs_front #(
    parameter int unsigned NUM_PAGES = ppfs_pkg::NUM_PAGES_DEF,
    parameter int unsigned IDX_W     = $clog2(NUM_PAGES)
) (
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            req_type,
    input  logic [ppfs_pkg::ADDR_W-1:0]     page_address,
    input  logic [ppfs_pkg::ADDR_W-1:0]     base_page,
    input  logic                            queue_full,
    output logic                            push,
    output ppfs_pkg::req_kind_t             kind,
    output logic [IDX_W-1:0]                idx
);
    logic [ppfs_pkg::ADDR_W:0] diff;
    logic                      aligned;
    logic                      in_range;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // borrow out of the subtract means the address lies below the base
    assign diff     = {1'b0, page_address} - {1'b0, base_page};
    assign aligned  = (page_address[ppfs_pkg::PAGE_SHIFT-1:0] == '0);
    assign in_range = !diff[ppfs_pkg::ADDR_W] &&
                      (ppfs_pkg::ADDR_W'(diff[ppfs_pkg::ADDR_W-1:ppfs_pkg::PAGE_SHIFT]) <
                       ppfs_pkg::ADDR_W'(NUM_PAGES));
    assign idx      = diff[ppfs_pkg::PAGE_SHIFT +: IDX_W];

    always_comb begin
        if (!req_type) begin
            kind = ppfs_pkg::KIND_ALLOC;
        end else if (aligned && in_range) begin
            kind = ppfs_pkg::KIND_FREE;
        end else begin
            kind = ppfs_pkg::KIND_BAD;
        end
    end
endmodule

>>> src/ppfs_queue.sv
// Short queue of classified requests between intake and execution.
`timescale 1ns / 1ps
module ppfs_queue #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = ppfs_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

>>> src/ppfs_back.sv
// Request execution: free stack, allocation bits and result register.
`timescale 1ns / 1ps
`include "physical_page_free_stack_macros.svh"
module ppfs_back #(
    parameter int unsigned NUM_PAGES = ppfs_pkg::NUM_PAGES_DEF,
    parameter int unsigned IDX_W     = $clog2(NUM_PAGES)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  ppfs_pkg::req_kind_t         q_kind,
    input  logic [IDX_W-1:0]            q_idx,
    output logic                        q_pop,
    input  logic [ppfs_pkg::ADDR_W-1:0] base_page,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ppfs_pkg::status_t           m_status,
    output logic [ppfs_pkg::ADDR_W-1:0] m_address
);
    localparam int unsigned CNT_W = $clog2(NUM_PAGES + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_PAGES);

    logic [IDX_W-1:0] stack_mem [NUM_PAGES];
    logic             alloc_mem [NUM_PAGES];

    ppfs_pkg::back_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    // lowest stack fill ever reached; slots below it were never written and read as their reset index
    logic [CNT_W-1:0]      low_reg, low_next;
    ppfs_pkg::req_kind_t   kind_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      stack_rd_reg;
    logic                  alloc_rd_reg;
    logic                  m_valid_reg, m_valid_next;
    ppfs_pkg::status_t     m_status_reg, m_status_next;
    logic [ppfs_pkg::ADDR_W-1:0] m_address_reg, m_address_next;

    logic [CNT_W-1:0]      top_pos;
    logic                  top_fresh;
    logic [IDX_W-1:0]      popped_idx;
    logic                  bit_known;
    logic                  rd_en;
    logic                  commit;
    ppfs_pkg::status_t     res_status;
    logic [ppfs_pkg::ADDR_W-1:0] res_address;
    logic                  stack_we;
    logic                  alloc_we;
    logic [IDX_W-1:0]      alloc_waddr;
    logic                  alloc_wdata;

    assign top_pos    = count_reg - CNT_W'(1);
    assign top_fresh  = (top_pos < low_reg);
    assign popped_idx = top_fresh ? IDX_W'(N_CNT - count_reg) : stack_rd_reg;
    // pages at or above NUM_PAGES - low were never handed out
    assign bit_known  = (CNT_W'(idx_reg) < (N_CNT - low_reg));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        low_next       = low_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        commit         = 1'b0;
        res_status     = ppfs_pkg::ST_BAD_ADDRESS;
        res_address    = '0;
        stack_we       = 1'b0;
        alloc_we       = 1'b0;
        alloc_waddr    = idx_reg;
        alloc_wdata    = 1'b0;

        case (kind_reg)
            ppfs_pkg::KIND_ALLOC: begin
                if (count_reg == '0) begin
                    res_status = ppfs_pkg::ST_NONE_FREE;
                end else begin
                    res_status  = ppfs_pkg::ST_ALLOCATED;
                    res_address = base_page +
                                  (ppfs_pkg::ADDR_W'(popped_idx) << ppfs_pkg::PAGE_SHIFT);
                end
            end
            ppfs_pkg::KIND_FREE: begin
                if (!(bit_known && alloc_rd_reg) || count_reg == N_CNT) begin
                    res_status = ppfs_pkg::ST_NOT_ALLOCATED;
                end else begin
                    res_status = ppfs_pkg::ST_FREED;
                end
            end
            default: begin
                res_status = ppfs_pkg::ST_BAD_ADDRESS;
            end
        endcase

        case (state_reg)
            ppfs_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    state_next = ppfs_pkg::B_EXEC;
                end
            end
            ppfs_pkg::B_EXEC: begin
                // hold until the result register can take the beat
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = ppfs_pkg::B_IDLE;
                    if (res_status == ppfs_pkg::ST_ALLOCATED) begin
                        count_next  = top_pos;
                        low_next    = top_fresh ? top_pos : low_reg;
                        alloc_we    = 1'b1;
                        alloc_waddr = popped_idx;
                        alloc_wdata = 1'b1;
                    end else if (res_status == ppfs_pkg::ST_FREED) begin
                        count_next  = count_reg + CNT_W'(1);
                        stack_we    = 1'b1;
                        alloc_we    = 1'b1;
                        alloc_waddr = idx_reg;
                        alloc_wdata = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ppfs_pkg::B_IDLE;
            end
        endcase

        m_valid_next   = commit ? 1'b1 : (m_valid_reg && !m_ready);
        m_status_next  = commit ? res_status : m_status_reg;
        m_address_next = commit ? res_address : m_address_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ppfs_pkg::B_IDLE;
            count_reg   <= N_CNT;
            low_reg     <= N_CNT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            low_reg     <= low_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg  <= m_status_next;
        m_address_reg <= m_address_next;
        if (q_pop) begin
            kind_reg <= q_kind;
            idx_reg  <= q_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[count_reg[IDX_W-1:0]] <= idx_reg;
        end
        if (rd_en) begin
            stack_rd_reg <= stack_mem[top_pos[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (alloc_we) begin
            alloc_mem[alloc_waddr] <= alloc_wdata;
        end
        if (rd_en) begin
            alloc_rd_reg <= alloc_mem[q_idx];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;

    `PPFS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= N_CNT, "free count over range")
    `PPFS_ASSERT_IMPL(a_low_mark, aclk, aresetn, 1'b1, low_reg <= count_reg, "low mark above count")
    `PPFS_ASSERT_NEXT(a_grant_pops, aclk, aresetn, commit && (res_status == ppfs_pkg::ST_ALLOCATED), count_reg == $past(count_reg) - CNT_W'(1), "grant did not pop")
endmodule

>>> src/physical_page_free_stack.sv
// Flow: an accepted request enters the queue, then the execution stage, which
// reads the free stack and allocation memories, then writes them and commits its
// result once the output register is free, before it takes the next request.
// Reset: synchronous, active low; no clearing pass, a low-water mark on the
// stack stands in for the initial page order and the cleared allocation bits.
`timescale 1ns / 1ps
module physical_page_free_stack #(
    parameter int unsigned NUM_PAGES = ppfs_pkg::NUM_PAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // page_address
    input  logic                          s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // granted_address
    output logic [2:0]                    m_tuser,   // status
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int unsigned IDX_W = $clog2(NUM_PAGES);
    localparam int unsigned Q_W   = 2 + IDX_W;

    logic [31:0]         base_reg;
    logic [31:0]         base_page;
    logic                reg_hit;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    ppfs_pkg::req_kind_t f_kind;
    logic [IDX_W-1:0]    f_idx;
    logic [Q_W-1:0]      q_head;
    ppfs_pkg::status_t   status;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[ppfs_pkg::PADDR_W-1:2] == ppfs_pkg::REG_BASE_ADDRESS);
    assign prdata    = reg_hit ? base_reg : '0;
    assign base_page = {base_reg[31:ppfs_pkg::PAGE_SHIFT], {ppfs_pkg::PAGE_SHIFT{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= ppfs_pkg::BASE_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            base_reg <= pwdata;
        end
    end

    ppfs_front #(
        .NUM_PAGES (NUM_PAGES),
        .IDX_W     (IDX_W)
    ) u_front (
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .req_type     (s_tuser),
        .page_address (s_tdata),
        .base_page    (base_page),
        .queue_full   (q_full),
        .push         (push),
        .kind         (f_kind),
        .idx          (f_idx)
    );

    ppfs_queue #(
        .WIDTH (Q_W),
        .DEPTH (ppfs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({f_idx, f_kind}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    ppfs_back #(
        .NUM_PAGES (NUM_PAGES),
        .IDX_W     (IDX_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_kind    (ppfs_pkg::req_kind_t'(q_head[1:0])),
        .q_idx     (q_head[2 +: IDX_W]),
        .q_pop     (pop),
        .base_page (base_page),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_status  (status),
        .m_address (m_tdata)
    );

    assign m_tuser = status;
endmodule

>>> tb/tb.sv
// Self-checking testbench for the physical page free-stack allocator.
`timescale 1ns / 1ps
module tb;
    localparam int unsigned NUM_PAGES  = ppfs_pkg::NUM_PAGES_DEF;
    localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam logic [31:0] PAGE_BYTES = 32'd1 << ppfs_pkg::PAGE_SHIFT;
    localparam logic        REQ_ALLOC  = 1'b0;
    localparam logic        REQ_FREE   = 1'b1;
    localparam logic [ppfs_pkg::PADDR_W-1:0] BASE_ADDR_OFFSET =
        {ppfs_pkg::REG_BASE_ADDRESS, 2'b00};
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;

    // How the driver picks the address of a request when it goes on the bus.
    typedef enum {
        RQ_FIXED,
        RQ_ALLOC,
        RQ_FREE_LIVE,
        RQ_FREE_IDLE,
        RQ_FREE_UNALIGNED,
        RQ_FREE_OUTSIDE,
        RQ_FREE_RANDOM
    } req_pick_t;

    typedef struct {
        req_pick_t   pick;
        logic        req;
        logic [31:0] addr;
    } page_request_t;

    typedef struct packed {
        ppfs_pkg::status_t status;
        logic [31:0]       granted;
    } page_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // page_address
    logic        s_tuser  = 1'b0;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // granted_address
    logic [2:0]  m_tuser;          // status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [ppfs_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Allocator state as the testbench sees it.
    logic [31:0]                    base_setting;
    logic [IDX_W-1:0]               free_pages [NUM_PAGES];
    logic [CNT_W-1:0]               free_depth;
    bit                             page_in_use [NUM_PAGES];

    page_request_t page_requests [$];
    page_reply_t   pending_replies [$];
    int unsigned   items_queued = 0;
    int unsigned   replies_seen = 0;
    int unsigned   mismatches   = 0;
    bit            req_taken    = 1'b0;
    int unsigned   burst_left   = 1;
    int unsigned   gap_left     = 0;
    int unsigned   stall_cycle  = 0;
    int unsigned   stall_mode   = 0;
    int unsigned   hold_left    = 0;
    bit            hold_done    = 1'b0;
    int unsigned   quiet_cycles = 0;

    physical_page_free_stack i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic page_reply_t serve_page_request(logic req, logic [31:0] addr);
        page_reply_t r;
        logic [31:0] base;
        logic [32:0] limit;
        int unsigned idx;
        base = base_setting & ~(PAGE_BYTES - 1);
        r.granted = '0;
        if (req == REQ_ALLOC) begin
            if (free_depth == 0) begin
                r.status = ppfs_pkg::ST_NONE_FREE;
            end else begin
                idx = 32'(free_pages[free_depth - 1]);
                free_depth--;
                page_in_use[idx] = 1'b1;
                r.granted = base + (idx << ppfs_pkg::PAGE_SHIFT);
                r.status = ppfs_pkg::ST_ALLOCATED;
            end
        end else begin
            // compare against the end without wrapping past 4 GB
            limit = {1'b0, base} + (33'(NUM_PAGES) << ppfs_pkg::PAGE_SHIFT);
            if ((addr & (PAGE_BYTES - 1)) != 0 || addr < base || {1'b0, addr} >= limit) begin
                r.status = ppfs_pkg::ST_BAD_ADDRESS;
            end else begin
                idx = (addr - base) >> ppfs_pkg::PAGE_SHIFT;
                if (!page_in_use[idx] || free_depth >= NUM_PAGES) begin
                    r.status = ppfs_pkg::ST_NOT_ALLOCATED;
                end else begin
                    free_pages[free_depth] = IDX_W'(idx);
                    free_depth++;
                    page_in_use[idx] = 1'b0;
                    r.status = ppfs_pkg::ST_FREED;
                end
            end
        end
        return r;
    endfunction

    function automatic bit find_page(input bit want_in_use, output int unsigned idx);
        int unsigned start;
        start = $urandom_range(0, NUM_PAGES - 1);
        for (int unsigned i = 0; i < NUM_PAGES; i++) begin
            idx = (start + i) % NUM_PAGES;
            if (page_in_use[idx] == want_in_use) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_request(input req_pick_t pick, input logic req, input logic [31:0] addr);
        page_request_t item;
        item.pick = pick;
        item.req  = req;
        item.addr = addr;
        page_requests.push_back(item);
        items_queued++;
    endtask

    task automatic add_mix(input int unsigned count, input int unsigned alloc_pct,
                           input int unsigned live_pct);
        int unsigned r;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                add_request(RQ_ALLOC, REQ_ALLOC, '0);
            end else if (r < alloc_pct + live_pct) begin
                add_request(RQ_FREE_LIVE, REQ_FREE, '0);
            end else begin
                case ($urandom_range(0, 3))
                    0: add_request(RQ_FREE_IDLE, REQ_FREE, '0);
                    1: add_request(RQ_FREE_UNALIGNED, REQ_FREE, '0);
                    2: add_request(RQ_FREE_OUTSIDE, REQ_FREE, '0);
                    default: add_request(RQ_FREE_RANDOM, REQ_FREE, '0);
                endcase
            end
        end
    endtask

    // Return at a falling edge once every queued request has its result.
    task automatic wait_idle();
        while (replies_seen != items_queued) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_base(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR_OFFSET;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        base_setting = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        base_setting = ppfs_pkg::BASE_RESET;
        for (int unsigned k = 0; k < NUM_PAGES; k++) begin
            free_pages[k]  = IDX_W'(NUM_PAGES - 1 - k);
            page_in_use[k] = 1'b0;
        end
        free_depth = CNT_W'(NUM_PAGES);

        // directed pass at the reset base: pages 0x0040_0000 up to 0x0080_0000
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_0000);
        add_request(RQ_FIXED, REQ_ALLOC, 32'hFFFF_FFFF);
        add_request(RQ_FIXED, REQ_ALLOC, 32'h0000_0000);
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_0000);
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_0000);
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_1800);
        add_request(RQ_FIXED, REQ_FREE,  32'h003F_F000);
        add_request(RQ_FIXED, REQ_FREE,  32'h0080_0000);
        add_request(RQ_FIXED, REQ_FREE,  32'h007F_F000);
        add_request(RQ_FIXED, REQ_FREE,  32'h0000_0000);
        add_request(RQ_FIXED, REQ_FREE,  32'hFFFF_FFFF);
        add_request(RQ_FIXED, REQ_FREE,  32'hFFFF_F000);
        add_request(RQ_FIXED, REQ_ALLOC, 32'h5555_5555);
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_1000);
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_0FFF);
        add_request(RQ_FIXED, REQ_ALLOC, 32'hAAAA_AAAA);
        add_request(RQ_FIXED, REQ_FREE,  32'h0040_0001);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // low bits of the base are ignored
        write_base(32'h003F_FFFF);
        add_mix(60, 80, 10);
        wait_idle();

        // run the stack dry and keep asking
        write_base(32'h0000_0000);
        add_mix(free_depth + 16, 100, 0);
        wait_idle();

        write_base(32'hFFC0_0000);
        add_mix(40, 25, 55);
        wait_idle();

        write_base($urandom_range(0, 32'hFFC0_0000));
        add_mix(20, 50, 30);
        wait_idle();
        repeat (10) @(negedge aclk);

        if (pending_replies.size() != 0) begin
            $error("%0d results never arrived", pending_replies.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("physical_page_free_stack: match");
        end else begin
            $display("physical_page_free_stack: mismatch");
        end
        $finish;
    end

    // Present the next request once the previous beat has gone.
    always @(negedge aclk) begin : drive_requests
        page_request_t next_req;
        logic [31:0]   base;
        logic [32:0]   limit;
        logic [31:0]   addr;
        int unsigned   idx;
        if (aresetn && (!s_tvalid || req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (page_requests.size() > 0) begin
                next_req = page_requests.pop_front();
                base  = base_setting & ~(PAGE_BYTES - 1);
                limit = {1'b0, base} + (33'(NUM_PAGES) << ppfs_pkg::PAGE_SHIFT);
                case (next_req.pick)
                    RQ_FIXED: addr = next_req.addr;
                    RQ_FREE_LIVE: begin
                        if (!find_page(1'b1, idx)) idx = $urandom_range(0, NUM_PAGES - 1);
                        addr = base + (idx << ppfs_pkg::PAGE_SHIFT);
                    end
                    RQ_FREE_IDLE: begin
                        if (!find_page(1'b0, idx)) idx = $urandom_range(0, NUM_PAGES - 1);
                        addr = base + (idx << ppfs_pkg::PAGE_SHIFT);
                    end
                    RQ_FREE_UNALIGNED: begin
                        addr = base
                               + ($urandom_range(0, NUM_PAGES - 1) << ppfs_pkg::PAGE_SHIFT)
                               + $urandom_range(1, PAGE_BYTES - 1);
                    end
                    RQ_FREE_OUTSIDE: begin
                        if (!limit[32] && (base == 0 || $urandom_range(0, 1) == 1)) begin
                            addr = $urandom_range(0, 1) ? limit[31:0]
                                 : $urandom_range(limit[31:0], 32'hFFFF_FFFF);
                        end else begin
                            addr = $urandom_range(0, 1) ? base - PAGE_BYTES
                                 : $urandom_range(0, base - 1);
                        end
                    end
                    default: addr = $urandom;
                endcase
                s_tuser  <= next_req.req;
                s_tdata  <= addr;
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: switch among stall patterns, hold off once for a long stretch.
    always @(negedge aclk) begin
        stall_cycle++;
        if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && replies_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (stall_cycle % 7) < 3;
            endcase
        end
    end

    always @(posedge aclk) begin : check_replies
        page_reply_t want;
        req_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_replies.push_back(serve_page_request(s_tuser, s_tdata));
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    $error("unexpected result: status %0d granted_address %h", m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== want.granted) begin
                        $error("granted_address: expected %h, got %h", want.granted, m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stop a hung run: count cycles in which no beat moves on either side.
    initial begin
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("physical_page_free_stack: mismatch");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/ppfs_pkg.sv
src/ppfs_front.sv
src/ppfs_queue.sv
src/ppfs_back.sv
src/physical_page_free_stack.sv
tb/tb.sv
